// ===== hw/rtl/multi_channel_tachometer_top_assert.svh =====
// assertion macros for the tachometer top level
`ifndef MULTI_CHANNEL_TACHOMETER_TOP_ASSERT_SVH
`define MULTI_CHANNEL_TACHOMETER_TOP_ASSERT_SVH

// a holds at an edge, b holds in the cycle after
`define MCT_ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("assertion failed");

// a implies b at the same edge
`define MCT_ASSERT_SAME(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("assertion failed");

`endif

// ===== hw/rtl/mct_pkg.sv =====
// ----------------------------------------------------------------------------
// mct_pkg
// shared types and constants of the three-channel tachometer
// ----------------------------------------------------------------------------
package mct_pkg;

   localparam int unsigned CountFreq = 100000;
   localparam int unsigned ChanCount = 3;
   localparam logic [63:0] RpmScale = 64'(60) * 64'(CountFreq);
   localparam int unsigned DivSteps = 64;

   localparam logic [1:0] OP_TICK   = 2'd0;
   localparam logic [1:0] OP_PULSE  = 2'd1;
   localparam logic [1:0] OP_UPDATE = 2'd2;
   localparam logic [1:0] OP_ADC    = 2'd3;

   localparam logic [2:0] REG_PPR0 = 3'd0;
   localparam logic [2:0] REG_PPR1 = 3'd1;
   localparam logic [2:0] REG_PPR2 = 3'd2;
   localparam logic [2:0] REG_MAX0 = 3'd3;
   localparam logic [2:0] REG_MAX1 = 3'd4;
   localparam logic [2:0] REG_MAX2 = 3'd5;
   localparam logic [2:0] REG_THR  = 3'd6;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_PMUL1,
      ST_PMUL2,
      ST_PCHECK,
      ST_PDIV,
      ST_PWAIT,
      ST_PDONE,
      ST_UPREP,
      ST_UMUL1,
      ST_UMUL2,
      ST_UDIV,
      ST_UWAIT,
      ST_UDONE,
      ST_RESULT
   } state_type;

   typedef struct packed {
      logic        start;
      logic [63:0] dividend;
      logic [63:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [63:0] quotient;
      logic [63:0] remainder;
   } div_rsp_type;

   function automatic logic [31:0] sat_inc(input logic [31:0] a, input logic [31:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
   endfunction

endpackage

// ===== hw/rtl/mct_divider.sv =====
// ----------------------------------------------------------------------------
// mct_divider
// restoring divider, one quotient bit per cycle, 64 by 64 bits
// ----------------------------------------------------------------------------
module mct_divider
   import mct_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   logic [63:0] rem_ff, rem_in;
   logic [63:0] quo_ff, quo_in;
   logic [63:0] den_ff, den_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [64:0] trial;
   logic [64:0] shifted;

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      shifted = {rem_ff, quo_ff[63]};
      trial   = shifted - {1'b0, den_ff};
      if (req.start) begin
         rem_in  = '0;
         quo_in  = req.dividend;
         den_in  = req.divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[64]) begin
            rem_in = trial[63:0];
            quo_in = {quo_ff[62:0], 1'b1};
         end else begin
            rem_in = shifted[63:0];
            quo_in = {quo_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff + 7'd1;
         if (cnt_ff == 7'(DivSteps - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign rsp.done      = done_ff;
   assign rsp.quotient  = quo_ff;
   assign rsp.remainder = rem_ff;

endmodule

// ===== hw/rtl/multi_channel_tachometer_top.sv =====
// ----------------------------------------------------------------------------
// multi_channel_tachometer_top
// three-channel pulse-period tachometer with a shared multiplier and divider
// ----------------------------------------------------------------------------
// channel   direction  content
// req_      in         tdata: opcode[1:0], channel[3:2], adc_sample[15:4]
// rsp_      out        tdata: speed_rpm[15:0], pulse_accepted[16]
// csr_      in         write enable, index, 16-bit data
//
// tick words and adc words that start no pulse go from decode to the result
// word; a pulse passes two multiply states and a check, and an accepted one runs
// the 64-step divider for pass count modulo ppr. update words multiply, divide
// and wait per channel. one word is worked on at a time; req_tready is low until
// the result word is taken. synchronous active-high reset clears all counters.
`include "multi_channel_tachometer_top_assert.svh"

module multi_channel_tachometer_top
   import mct_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // opcode, channel, adc_sample
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // speed_rpm, pulse_accepted, zero fill
   input  logic        csr_wen,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   state_type state_ff, state_in;

   logic [31:0] period_ff [ChanCount];
   logic [31:0] sum_ff    [ChanCount];
   logic [31:0] pass_ff   [ChanCount];
   logic [31:0] cksum_ff  [ChanCount];
   logic [31:0] cktot_ff  [ChanCount];
   logic [15:0] speed_ff  [ChanCount];
   logic        prev_ff;
   logic [7:0]  ppr_ff    [ChanCount];
   logic [15:0] maxs_ff   [ChanCount];
   logic [15:0] thr_ff;

   logic [1:0]  op_ff;
   logic [1:0]  ch_ff;
   logic [11:0] adc_ff;
   logic [1:0]  sel_ff, sel_in;   // channel being worked on
   logic        acc_ff;
   logic [1:0]  mode_ff;          // 0 checkpoint, 1 raw, 2 decay
   logic [63:0] prod_ff;          // shared multiplier result
   logic [63:0] num_ff;

   logic [31:0] mul_a, mul_b;
   logic [63:0] mul_p;
   div_req_type dreq;
   div_rsp_type drsp;
   logic [15:0] rpm_new;
   logic        go_pulse;
   logic [1:0]  pch;
   logic [15:0] rsp_speed;

   mct_divider u_div (
      .clock (clock),
      .reset (reset),
      .req   (dreq),
      .rsp   (drsp)
   );

   // one shared 32x32 multiplier
   assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};

   assign pch = (op_ff == OP_ADC) ? 2'd0 : ch_ff;
   assign go_pulse = (op_ff == OP_PULSE && ch_ff < 2'd3) ||
                     (op_ff == OP_ADC && (20'(adc_ff) > 20'(thr_ff)) && !prev_ff);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_tvalid) state_in = ST_DECODE;
         ST_DECODE: begin
            if (op_ff == OP_UPDATE)  state_in = ST_UPREP;
            else if (go_pulse)       state_in = ST_PMUL1;
            else                     state_in = ST_RESULT;
         end
         ST_PMUL1:  state_in = ST_PMUL2;
         ST_PMUL2:  state_in = ST_PCHECK;
         ST_PCHECK: state_in = (prod_ff >= RpmScale) ? ST_PDIV : ST_RESULT;
         ST_PDIV:   state_in = ST_PWAIT;
         ST_PWAIT:  if (drsp.done) state_in = ST_PDONE;
         ST_PDONE:  state_in = ST_RESULT;
         ST_UPREP:  state_in = ST_UMUL1;
         ST_UMUL1:  state_in = ST_UMUL2;
         ST_UMUL2:  state_in = ST_UDIV;
         ST_UDIV:   state_in = ST_UWAIT;
         ST_UWAIT:  if (drsp.done) state_in = ST_UDONE;
         ST_UDONE:  state_in = (sel_ff == 2'd2) ? ST_RESULT : ST_UPREP;
         ST_RESULT: if (rsp_tready) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      dreq  = '0;
      unique case (state_ff)
         ST_PMUL1: begin
            mul_a = 32'(maxs_ff[pch]);
            mul_b = 32'(ppr_ff[pch]);
         end
         ST_PMUL2: begin
            // ppr times max speed fits in 24 bits
            mul_a = period_ff[pch];
            mul_b = prod_ff[31:0];
         end
         ST_PDIV: begin
            dreq.start    = 1'b1;
            dreq.dividend = {32'd0, pass_ff[pch]};
            dreq.divisor  = {56'd0, ppr_ff[pch]};
         end
         ST_UMUL1: begin
            mul_a = (mode_ff == 2'd0) ? cksum_ff[sel_ff] :
                    (mode_ff == 2'd1) ? sum_ff[sel_ff] : period_ff[sel_ff];
            mul_b = 32'(ppr_ff[sel_ff]);
         end
         ST_UMUL2: begin
            mul_a = (mode_ff == 2'd0) ? cktot_ff[sel_ff] :
                    (mode_ff == 2'd1) ? pass_ff[sel_ff] : 32'd1;
            mul_b = 32'(RpmScale);
         end
         ST_UDIV: begin
            dreq.start    = 1'b1;
            dreq.dividend = num_ff;
            dreq.divisor  = prod_ff;
         end
         default: ;
      endcase
   end

   assign sel_in = (state_ff == ST_UDONE) ? sel_ff + 2'd1 :
                   (state_ff == ST_DECODE) ? 2'd0 : sel_ff;

   // zero divisor reads as full scale
   assign rpm_new = (prod_ff == 64'd0 || drsp.quotient > 64'hFFFF) ? 16'hFFFF :
                    drsp.quotient[15:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         prev_ff  <= 1'b0;
         thr_ff   <= 16'd2048;
         for (int i = 0; i < ChanCount; i++) begin
            period_ff[i] <= '0;
            sum_ff[i]    <= '0;
            pass_ff[i]   <= '0;
            cksum_ff[i]  <= '0;
            cktot_ff[i]  <= '0;
            speed_ff[i]  <= '0;
            ppr_ff[i]    <= 8'd1;
            maxs_ff[i]   <= 16'hFFFF;
         end
      end else begin
         state_ff <= state_in;
         if (csr_wen) begin
            unique case (csr_index)
               REG_PPR0: ppr_ff[0]  <= csr_wdata[7:0];
               REG_PPR1: ppr_ff[1]  <= csr_wdata[7:0];
               REG_PPR2: ppr_ff[2]  <= csr_wdata[7:0];
               REG_MAX0: maxs_ff[0] <= csr_wdata;
               REG_MAX1: maxs_ff[1] <= csr_wdata;
               REG_MAX2: maxs_ff[2] <= csr_wdata;
               REG_THR:  thr_ff     <= csr_wdata;
               default:  ;
            endcase
         end
         unique case (state_ff)
            ST_DECODE: begin
               if (op_ff == OP_TICK) begin
                  for (int i = 0; i < ChanCount; i++)
                     period_ff[i] <= sat_inc(period_ff[i], 32'd1);
               end
               if (op_ff == OP_ADC) prev_ff <= (20'(adc_ff) > 20'(thr_ff));
            end
            ST_PCHECK: begin
               // 56-bit product checked against the minimum spacing
               if (prod_ff >= RpmScale) begin
                  pass_ff[pch]   <= sat_inc(pass_ff[pch], 32'd1);
                  sum_ff[pch]    <= sat_inc(sum_ff[pch], period_ff[pch]);
                  period_ff[pch] <= '0;
               end
            end
            ST_PDONE: begin
               // every ppr-th pass takes a checkpoint
               if (drsp.remainder == 64'd0) begin
                  cktot_ff[pch] <= pass_ff[pch];
                  cksum_ff[pch] <= sum_ff[pch];
               end
            end
            ST_UDONE: begin
               if (mode_ff != 2'd2) begin
                  speed_ff[sel_ff] <= rpm_new;
                  sum_ff[sel_ff]   <= '0;
                  cksum_ff[sel_ff] <= '0;
               end else if (rpm_new < speed_ff[sel_ff]) begin
                  speed_ff[sel_ff] <= rpm_new;
               end
               pass_ff[sel_ff]  <= '0;
               cktot_ff[sel_ff] <= '0;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      sel_ff <= sel_in;
      if (state_ff == ST_IDLE && req_tvalid) begin
         op_ff  <= req_tdata[1:0];
         ch_ff  <= req_tdata[3:2];
         adc_ff <= req_tdata[15:4];
         acc_ff <= 1'b0;
      end
      if (state_ff == ST_PCHECK) acc_ff <= (prod_ff >= RpmScale);
      if (state_ff == ST_UPREP)
         mode_ff <= (cktot_ff[sel_ff] != 0) ? 2'd0 :
                    (pass_ff[sel_ff] != 0) ? 2'd1 : 2'd2;
      if (state_ff == ST_PMUL1 || state_ff == ST_PMUL2 || state_ff == ST_UMUL1)
         prod_ff <= mul_p;
      if (state_ff == ST_UMUL2) num_ff <= mul_p;
   end

   // speed is stable while the result word waits
   assign rsp_speed = (ch_ff < 2'd3) ? speed_ff[ch_ff] : 16'd0;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_RESULT);
   assign rsp_tdata  = {7'd0, acc_ff, rsp_speed};

   `MCT_ASSERT_SAME(a_one_side, clock, reset, rsp_tvalid, !req_tready)
   `MCT_ASSERT_NEXT(a_accept_busy, clock, reset, req_tvalid && req_tready, !req_tready)
   `MCT_ASSERT_SAME(a_div_idle, clock, reset, drsp.done, state_ff == ST_UWAIT || state_ff == ST_PWAIT)

endmodule
